// ----- rtl/bfps_pkg.sv -----
`default_nettype none

package bfps_pkg;

   localparam logic [7:0] SYNC_LOW       = 8'h55;
   localparam logic [7:0] SYNC_HIGH      = 8'hAA;
   localparam logic [7:0] TABLE_RESET    = 8'd228;

   // byte offsets inside a 14-byte record
   localparam logic [3:0] OFS_AFTER_SYNC = 4'd2;
   localparam logic [3:0] OFS_ID_LO      = 4'd4;
   localparam logic [3:0] OFS_ID_HI      = 4'd5;
   localparam logic [3:0] OFS_X_LO       = 4'd6;
   localparam logic [3:0] OFS_X_HI       = 4'd7;
   localparam logic [3:0] OFS_W_LO       = 4'd10;
   localparam logic [3:0] OFS_W_HI       = 4'd11;
   localparam logic [3:0] OFS_LAST       = 4'd13;

   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] command;
      logic       id_out_of_range;
   } rsp_type;

   // an id reduced to what the decision needs: above 1, and its low bit
   typedef struct packed {
      logic over;
      logic lsb;
   } id_code_type;

   typedef struct packed {
      logic        is_record;
      logic        is_last;
      id_code_type id;
      logic [15:0] x;
      logic [15:0] width;
      logic [15:0] height;
   } rec_type;

   typedef struct packed {
      logic        enough;
      id_code_type largest_id;
      logic [15:0] largest_x;
      id_code_type second_id;
      logic [15:0] second_x;
   } snap_type;

endpackage

`default_nettype wire

// ----- rtl/blob_frame_pair_selector.sv -----
// Path: a result passes through the work queue, the s1 and s2 registers of the back end
//   and the result queue before it shows on rsp_data, and waits while the result queue is full.
// Throughput: one byte per cycle while req_full is low, with each byte parsed as it is
//   taken in the front end and one 16x16 multiply per record in the back end.
// Reset: synchronous, active high; clears parse state, both queues and the kept records,
//   and loads the command table with its default 228.
`default_nettype none

module blob_frame_pair_selector (
   input  wire logic              clock,
   input  wire logic              reset,
   // byte input, queue style
   input  wire logic              req_push,
   input  wire bfps_pkg::req_type  req_data,
   output logic                   req_full,
   // result output, queue style
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output bfps_pkg::rsp_type      rsp_data,
   // command table register
   input  wire logic              csr_we,
   input  wire logic [7:0]        csr_wdata
);
   import bfps_pkg::*;

   logic       [7:0] table_ff;
   logic             q_push, q_full, q_pop, q_empty;
   rec_type          q_push_data, q_data;
   logic             rsp_push, rsp_full;
   rsp_type          rsp_push_data;

   // command table: four 2-bit entries, entry 0 in the low bits
   always_ff @(posedge clock) begin
      if (reset) begin
         table_ff <= TABLE_RESET;
      end else if (csr_we) begin
         table_ff <= csr_wdata;
      end
   end

   // front end: sync search and record slicing; each completed record
   // and each frame end becomes one transfer into the work queue
   bfps_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // bytes are only taken while the work queue can absorb what they produce
   assign req_full = q_full;

   bfps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   // back end: area multiply, top-two tracking, final decision
   bfps_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .command_table (table_ff),
      .rsp_full      (rsp_full),
      .rsp_push      (rsp_push),
      .rsp_push_data (rsp_push_data)
   );

   bfps_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_push_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

`ifndef SYNTHESIS
   // front end never pushes into a full work queue
   a_q_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("work queue push while full");

   // back end never pushes a result into a full result queue
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(rsp_push && rsp_full))
      else $error("result queue push while full");

   // an out-of-range id always falls back to table entry 0
   a_flag_entry0: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.id_out_of_range) |-> (rsp_data.command == table_ff[1:0]))
      else $error("flagged result not from table entry 0");

   // a byte is only taken while the work queue has room
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (req_push && req_full) |-> !q_push)
      else $error("byte taken while work queue full");
`endif

endmodule

`default_nettype wire

// ----- rtl/bfps_front.sv -----
`default_nettype none

module bfps_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire bfps_pkg::req_type req_data,
   input  wire logic             q_full,
   output logic                  q_push,
   output bfps_pkg::rec_type     q_push_data
);
   import bfps_pkg::*;

   logic              sync_ff, sync_in;
   logic [7:0]        prev_ff, prev_in;
   logic [3:0]        ofs_ff, ofs_in;
   id_code_type       id_ff, id_in;
   logic [15:0]       x_ff, x_in;
   logic [15:0]       w_ff, w_in;
   logic              accept;
   logic              rec_done;
   logic [7:0]        b;

   assign accept = req_push && !q_full;
   assign b      = req_data.data_byte;

   always_comb begin
      sync_in  = sync_ff;
      prev_in  = prev_ff;
      ofs_in   = ofs_ff;
      id_in    = id_ff;
      x_in     = x_ff;
      w_in     = w_ff;
      rec_done = 1'b0;
      if (accept) begin
         if (!sync_ff) begin
            if (prev_ff == SYNC_LOW && b == SYNC_HIGH) begin
               sync_in = 1'b1;
               ofs_in  = OFS_AFTER_SYNC;
            end
         end else begin
            case (ofs_ff)
               OFS_ID_LO: begin
                  id_in.over = (b[7:1] != 7'd0);
                  id_in.lsb  = b[0];
               end
               OFS_ID_HI: id_in.over = id_ff.over || (b != 8'd0);
               OFS_X_LO:  x_in = {8'd0, b};
               OFS_X_HI:  x_in = {b, x_ff[7:0]};
               OFS_W_LO:  w_in = {8'd0, b};
               OFS_W_HI:  w_in = {b, w_ff[7:0]};
               OFS_LAST:  rec_done = 1'b1;
               default:   ;
            endcase
            if (ofs_ff >= OFS_LAST) begin
               ofs_in = 4'd0;
            end else begin
               ofs_in = ofs_ff + 4'd1;
            end
         end
         prev_in = b;
         // frame ends: start over with a fresh search
         if (req_data.last_byte) begin
            sync_in = 1'b0;
            prev_in = 8'd0;
            ofs_in  = 4'd0;
            id_in   = '0;
            x_in    = 16'd0;
            w_in    = 16'd0;
         end
      end
   end

   always_comb begin
      q_push_data.is_record = rec_done;
      q_push_data.is_last   = req_data.last_byte;
      q_push_data.id        = id_ff;
      q_push_data.x         = x_ff;
      q_push_data.width     = w_ff;
      q_push_data.height    = {b, prev_ff};
      q_push                = accept && (rec_done || req_data.last_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= 1'b0;
         prev_ff <= 8'd0;
         ofs_ff  <= 4'd0;
         id_ff   <= '0;
         x_ff    <= 16'd0;
         w_ff    <= 16'd0;
      end else begin
         sync_ff <= sync_in;
         prev_ff <= prev_in;
         ofs_ff  <= ofs_in;
         id_ff   <= id_in;
         x_ff    <= x_in;
         w_ff    <= w_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bfps_queue.sv -----
`default_nettype none

module bfps_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire bfps_pkg::rec_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output bfps_pkg::rec_type     pop_data,
   output logic                  empty
);
   import bfps_pkg::*;

   rec_type            mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_PTR_W:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bfps_rsp_queue.sv -----
`default_nettype none

module bfps_rsp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire bfps_pkg::rsp_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output bfps_pkg::rsp_type     pop_data,
   output logic                  empty
);
   import bfps_pkg::*;

   rsp_type              mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_PTR_W:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == (RSP_PTR_W+1)'(RSP_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bfps_back.sv -----
`default_nettype none

module bfps_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire bfps_pkg::rec_type  q_data,
   output logic                   q_pop,
   input  wire logic [7:0]        command_table,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output bfps_pkg::rsp_type      rsp_push_data
);
   import bfps_pkg::*;

   typedef struct packed {
      logic        is_record;
      logic        is_last;
      id_code_type id;
      logic [15:0] x;
      logic [31:0] area;
   } area_type;

   logic        adv;
   logic        s1_valid_ff, s1_valid_in;
   area_type    s1_ff;
   logic        s2_valid_ff, s2_valid_in;
   snap_type    s2_ff, s2_in;

   logic [1:0]  count_ff, count_in;
   id_code_type lg_id_ff, lg_id_in, sc_id_ff, sc_id_in;
   logic [15:0] lg_x_ff, lg_x_in, sc_x_ff, sc_x_in;
   logic [31:0] lg_area_ff, lg_area_in, sc_area_ff, sc_area_in;

   id_code_type left_id, right_id;
   logic [1:0]  idx;
   logic        flag;

   // the whole back end holds while a decision waits on a full result queue
   assign adv         = !(s2_valid_ff && rsp_full);
   assign q_pop       = adv && !q_empty;
   assign s1_valid_in = adv ? q_pop : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_ff.is_record <= q_data.is_record;
         s1_ff.is_last   <= q_data.is_last;
         s1_ff.id        <= q_data.id;
         s1_ff.x         <= q_data.x;
         s1_ff.area      <= {16'd0, q_data.width} * {16'd0, q_data.height};
      end
   end

   // top-two update, strict compares keep the earlier record on a tie
   always_comb begin
      count_in   = count_ff;
      lg_id_in   = lg_id_ff;
      lg_x_in    = lg_x_ff;
      lg_area_in = lg_area_ff;
      sc_id_in   = sc_id_ff;
      sc_x_in    = sc_x_ff;
      sc_area_in = sc_area_ff;
      if (s1_ff.is_record) begin
         if (s1_ff.area > lg_area_ff) begin
            sc_id_in   = lg_id_ff;
            sc_x_in    = lg_x_ff;
            sc_area_in = lg_area_ff;
            lg_id_in   = s1_ff.id;
            lg_x_in    = s1_ff.x;
            lg_area_in = s1_ff.area;
         end else if (s1_ff.area > sc_area_ff) begin
            sc_id_in   = s1_ff.id;
            sc_x_in    = s1_ff.x;
            sc_area_in = s1_ff.area;
         end
         if (!count_ff[1]) begin
            count_in = count_ff + 2'd1;
         end
      end
      s2_in.enough     = count_in[1];
      s2_in.largest_id = lg_id_in;
      s2_in.largest_x  = lg_x_in;
      s2_in.second_id  = sc_id_in;
      s2_in.second_x   = sc_x_in;
      s2_valid_in      = s1_valid_ff && s1_ff.is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         count_ff    <= 2'd0;
         lg_id_ff    <= '0;
         lg_x_ff     <= 16'd0;
         lg_area_ff  <= 32'd0;
         sc_id_ff    <= '0;
         sc_x_ff     <= 16'd0;
         sc_area_ff  <= 32'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (adv) begin
            s2_valid_ff <= s2_valid_in;
            if (s1_valid_ff) begin
               if (s1_ff.is_last) begin
                  count_ff   <= 2'd0;
                  lg_id_ff   <= '0;
                  lg_x_ff    <= 16'd0;
                  lg_area_ff <= 32'd0;
                  sc_id_ff   <= '0;
                  sc_x_ff    <= 16'd0;
                  sc_area_ff <= 32'd0;
               end else begin
                  count_ff   <= count_in;
                  lg_id_ff   <= lg_id_in;
                  lg_x_ff    <= lg_x_in;
                  lg_area_ff <= lg_area_in;
                  sc_id_ff   <= sc_id_in;
                  sc_x_ff    <= sc_x_in;
                  sc_area_ff <= sc_area_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_in) begin
         s2_ff <= s2_in;
      end
   end

   // decision: smaller x goes left, equal x keeps the larger on the left
   always_comb begin
      if (s2_ff.largest_x > s2_ff.second_x) begin
         left_id  = s2_ff.second_id;
         right_id = s2_ff.largest_id;
      end else begin
         left_id  = s2_ff.largest_id;
         right_id = s2_ff.second_id;
      end
      flag = s2_ff.enough && (left_id.over || right_id.over);
      idx  = (s2_ff.enough && !flag) ? {left_id.lsb, right_id.lsb} : 2'd0;
      rsp_push_data.command         = command_table[{idx, 1'b0} +: 2];
      rsp_push_data.id_out_of_range = flag;
      rsp_push                      = s2_valid_ff && !rsp_full;
   end

endmodule

`default_nettype wire
